[rtl/lbdf_pkg.sv]
// shared types, constants and codes of the luminance bloom disk filter
package lbdf_pkg;

   localparam int MAX_RADIUS_DEF = 8;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [15:0] RST_WEIGHT_RED   = 16'd19595;
   localparam logic [15:0] RST_WEIGHT_GREEN = 16'd38470;
   localparam logic [15:0] RST_WEIGHT_BLUE  = 16'd7471;
   localparam logic [15:0] RST_THRESHOLD    = 16'd4096;
   localparam logic [23:0] RST_GAIN         = 24'd1304;
   localparam logic [3:0]  RST_RADIUS       = 4'd4;
   localparam logic [10:0] RST_WIDTH        = 11'd1024;
   localparam logic [10:0] RST_HEIGHT       = 11'd1024;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LUMA_WEIGHT_RED   = 3'd0,
      REG_LUMA_WEIGHT_GREEN = 3'd1,
      REG_LUMA_WEIGHT_BLUE  = 3'd2,
      REG_GLOW_THRESHOLD    = 3'd3,
      REG_GLOW_GAIN         = 3'd4,
      REG_DISK_RADIUS       = 3'd5,
      REG_FRAME_WIDTH       = 3'd6,
      REG_FRAME_HEIGHT      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [15:0] weight_red;
      logic [15:0] weight_green;
      logic [15:0] weight_blue;
      logic [15:0] threshold;
      logic [23:0] gain;
      logic [3:0]  radius;
      logic [10:0] width;
      logic [10:0] height;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LUMA_R, ST_LUMA_G, ST_LUMA_B, ST_CLAMP, ST_DIV, ST_MUL_FACTOR,
      ST_MUL_GAIN, ST_STORE, ST_FETCH, ST_DISK, ST_DRAIN, ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_ACCEPT, OP_LUMA_R, OP_LUMA_G, OP_LUMA_B, OP_CLAMP, OP_DIV,
      OP_MUL_FACTOR, OP_MUL_GAIN, OP_STORE, OP_FETCH, OP_DISK, OP_DRAIN, OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic full_factor;
      logic div_last;
      logic emit;
      logic disk_last;
      logic out_free;
   } sts_type;

endpackage

[rtl/lbdf_ifs.sv]
// channel interfaces of the luminance bloom disk filter
interface lbdf_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] in_red;
   logic [15:0] in_green;
   logic [15:0] in_blue;
   logic [15:0] in_alpha;
   logic        is_pad;
   modport source(output valid, in_red, in_green, in_blue, in_alpha, is_pad, input ready);
   modport sink(input valid, in_red, in_green, in_blue, in_alpha, is_pad, output ready);
endinterface

interface lbdf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_red;
   logic [15:0] out_green;
   logic [15:0] out_blue;
   logic [15:0] out_alpha;
   logic        end_of_frame;
   modport source(output valid, out_red, out_green, out_blue, out_alpha, end_of_frame,
                  input ready);
   modport sink(input valid, out_red, out_green, out_blue, out_alpha, end_of_frame,
                output ready);
endinterface

interface lbdf_csr_if;
   logic                               valid;
   logic                               ready;
   logic [lbdf_pkg::CSR_INDEX_W-1:0]   index;
   logic [lbdf_pkg::CSR_DATA_W-1:0]    data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

[rtl/lbdf_ram.sv]
// generic single write, single read ram with registered read
module lbdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/lbdf_ctrl.sv]
// sequencer that steps one pixel through the datapath
module lbdf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lbdf_pkg::sts_type sts,
   output lbdf_pkg::cmd_type cmd
);
   lbdf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbdf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = lbdf_pkg::OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         lbdf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = lbdf_pkg::OP_ACCEPT;
               state_in = lbdf_pkg::ST_LUMA_R;
            end
         end
         lbdf_pkg::ST_LUMA_R: begin
            cmd.op   = lbdf_pkg::OP_LUMA_R;
            state_in = lbdf_pkg::ST_LUMA_G;
         end
         lbdf_pkg::ST_LUMA_G: begin
            cmd.op   = lbdf_pkg::OP_LUMA_G;
            state_in = lbdf_pkg::ST_LUMA_B;
         end
         lbdf_pkg::ST_LUMA_B: begin
            cmd.op   = lbdf_pkg::OP_LUMA_B;
            state_in = lbdf_pkg::ST_CLAMP;
         end
         lbdf_pkg::ST_CLAMP: begin
            cmd.op   = lbdf_pkg::OP_CLAMP;
            state_in = lbdf_pkg::ST_DIV;
         end
         lbdf_pkg::ST_DIV: begin
            if (sts.full_factor) begin
               state_in = lbdf_pkg::ST_MUL_FACTOR;
            end else begin
               cmd.op = lbdf_pkg::OP_DIV;
               if (sts.div_last) begin
                  state_in = lbdf_pkg::ST_MUL_FACTOR;
               end
            end
         end
         lbdf_pkg::ST_MUL_FACTOR: begin
            cmd.op   = lbdf_pkg::OP_MUL_FACTOR;
            state_in = lbdf_pkg::ST_MUL_GAIN;
         end
         lbdf_pkg::ST_MUL_GAIN: begin
            cmd.op   = lbdf_pkg::OP_MUL_GAIN;
            state_in = lbdf_pkg::ST_STORE;
         end
         lbdf_pkg::ST_STORE: begin
            cmd.op   = lbdf_pkg::OP_STORE;
            state_in = lbdf_pkg::ST_FETCH;
         end
         lbdf_pkg::ST_FETCH: begin
            cmd.op   = lbdf_pkg::OP_FETCH;
            state_in = sts.emit ? lbdf_pkg::ST_DISK : lbdf_pkg::ST_IDLE;
         end
         lbdf_pkg::ST_DISK: begin
            cmd.op = lbdf_pkg::OP_DISK;
            if (sts.disk_last) begin
               state_in = lbdf_pkg::ST_DRAIN;
            end
         end
         lbdf_pkg::ST_DRAIN: begin
            cmd.op   = lbdf_pkg::OP_DRAIN;
            state_in = lbdf_pkg::ST_EMIT;
         end
         lbdf_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.op   = lbdf_pkg::OP_EMIT;
               state_in = lbdf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lbdf_pkg::ST_IDLE;
         end
      endcase
   end
endmodule

[rtl/lbdf_datapath.sv]
// glow arithmetic, line stores, disk gather and output register
module lbdf_datapath #(
   parameter int MAX_RADIUS = lbdf_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = lbdf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lbdf_pkg::MAX_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  lbdf_pkg::cfg_type cfg,
   input  lbdf_pkg::cmd_type cmd,
   output lbdf_pkg::sts_type sts,
   input  logic [15:0]       req_red,
   input  logic [15:0]       req_green,
   input  logic [15:0]       req_blue,
   input  logic [15:0]       req_alpha,
   input  logic              req_pad,
   lbdf_rsp_if.source        rsp_if
);
   localparam int DISK_ROWS  = 2 * MAX_RADIUS + 1;
   localparam int GLOW_DEPTH = DISK_ROWS * MAX_WIDTH
                               + ((MAX_RADIUS >= MAX_WIDTH) ? (MAX_RADIUS + 1) : 0);
   localparam int PIX_DEPTH  = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
   localparam int GAW  = $clog2(GLOW_DEPTH);
   localparam int PAW  = $clog2(PIX_DEPTH);
   localparam int RADW = $clog2(MAX_RADIUS + 1);
   localparam int SW   = RADW + 1;
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int RW   = HW + 1;
   localparam int QW   = RW + WW;
   localparam int DW   = $clog2(PIX_DEPTH + 1);
   localparam int CW   = QW + DW;
   localparam int BW   = DW + 1;
   localparam int XW   = ((BW > GAW) ? BW : GAW) + 1;
   localparam int PXW  = DW + 1;
   localparam int TW   = 24 + $clog2(DISK_ROWS * DISK_ROWS + 1);

   // clamped settings
   logic [RADW-1:0] r_c;
   logic [WW-1:0]   w_c;
   logic [HW-1:0]   h_c;

   assign r_c = (32'(cfg.radius) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(cfg.radius);
   assign w_c = (cfg.width == 11'd0) ? WW'(1) :
                ((32'(cfg.width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg.width));
   assign h_c = (cfg.height == 11'd0) ? HW'(1) :
                ((32'(cfg.height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg.height));

   // registers
   logic [63:0]           pix_ff;
   logic                  pad_ff;
   logic [33:0]           acc_ff;
   logic [15:0]           luma_ff;
   logic                  full_ff;
   logic [15:0]           rem_ff;
   logic [15:0]           quo_ff;
   logic [3:0]            cnt_ff;
   logic [15:0]           prod_ff;
   logic [23:0]           glow_ff;
   logic [DW-1:0]         rw_ff;
   logic [DW-1:0]         delay_ff;
   logic [QW-1:0]         q_ff;
   logic                  emit_ff;
   logic [WW-1:0]         in_col_ff;
   logic [RW-1:0]         in_row_ff;
   logic [WW-1:0]         out_col_ff;
   logic [RW-1:0]         out_row_ff;
   logic [GAW-1:0]        glow_wp_ff;
   logic [GAW-1:0]        cur_g_ff;
   logic [PAW-1:0]        pix_wp_ff;
   logic [63:0]           src_ff;
   logic signed [SW-1:0]  i_ff;
   logic signed [SW-1:0]  j_ff;
   logic [BW-1:0]         back_ff;
   logic [BW-1:0]         row_back_ff;
   logic                  rd_valid_ff;
   logic [TW-1:0]         total_ff;
   logic                  rsp_valid_ff;
   logic [15:0]           rsp_red_ff;
   logic [15:0]           rsp_green_ff;
   logic [15:0]           rsp_blue_ff;
   logic [15:0]           rsp_alpha_ff;
   logic                  rsp_eof_ff;

   // arithmetic
   logic [15:0] wt_sel;
   logic [15:0] ch_sel;
   logic [31:0] wprod;
   logic [15:0] luma_c;
   logic [16:0] rem2;
   logic        rem_ge;
   logic [16:0] factor;
   logic [32:0] mf;
   logic [39:0] mg;

   always_comb begin
      case (cmd.op)
         lbdf_pkg::OP_LUMA_G: begin
            wt_sel = cfg.weight_green;
            ch_sel = pix_ff[31:16];
         end
         lbdf_pkg::OP_LUMA_B: begin
            wt_sel = cfg.weight_blue;
            ch_sel = pix_ff[47:32];
         end
         default: begin
            wt_sel = cfg.weight_red;
            ch_sel = pix_ff[15:0];
         end
      endcase
   end

   assign wprod  = 32'(wt_sel) * 32'(ch_sel);
   assign luma_c = (acc_ff[33:32] != 2'b00) ? 16'hFFFF : acc_ff[31:16];
   assign rem2   = {rem_ff, 1'b0};
   assign rem_ge = rem2 >= {1'b0, cfg.threshold};
   assign factor = full_ff ? 17'h10000 : {1'b0, quo_ff};
   assign mf     = 33'(luma_ff) * 33'(factor);
   assign mg     = 40'(prod_ff) * 40'(cfg.gain);

   // pixel delay line read address
   logic [PXW-1:0] pw_x;
   logic [PXW-1:0] dl_x;
   logic [PXW-1:0] pix_rd_x;
   assign pw_x     = PXW'(pix_wp_ff);
   assign dl_x     = PXW'(delay_ff);
   assign pix_rd_x = (pw_x >= dl_x) ? (pw_x - dl_x) : (pw_x + PXW'(PIX_DEPTH) - dl_x);

   // disk tap address and membership
   logic [XW-1:0]          bm_x;
   logic [XW-1:0]          bmod_x;
   logic [XW-1:0]          cg_x;
   logic [XW-1:0]          glow_rd_x;
   logic [RADW-1:0]        ai;
   logic [RADW-1:0]        aj;
   logic [2*RADW:0]        d2;
   logic [2*RADW:0]        rr;
   logic signed [RW+1:0]   y_pos;
   logic signed [WW+1:0]   x_pos;
   logic                   in_disk;
   logic                   j_end;
   logic                   i_end;

   assign bm_x      = XW'(back_ff);
   assign bmod_x    = (bm_x >= XW'(GLOW_DEPTH)) ? (bm_x - XW'(GLOW_DEPTH)) : bm_x;
   assign cg_x      = XW'(cur_g_ff);
   assign glow_rd_x = (cg_x >= bmod_x) ? (cg_x - bmod_x) : (cg_x + XW'(GLOW_DEPTH) - bmod_x);
   assign ai        = i_ff[SW-1] ? RADW'(-i_ff) : RADW'(i_ff);
   assign aj        = j_ff[SW-1] ? RADW'(-j_ff) : RADW'(j_ff);
   assign d2        = (2*RADW+1)'(ai * ai) + (2*RADW+1)'(aj * aj);
   assign rr        = (2*RADW+1)'(r_c * r_c);
   assign y_pos     = $signed({2'b00, out_row_ff}) + $signed({{(RW+2-SW){i_ff[SW-1]}}, i_ff});
   assign x_pos     = $signed({2'b00, out_col_ff}) + $signed({{(WW+2-SW){j_ff[SW-1]}}, j_ff});
   assign in_disk   = (d2 <= rr)
                      && !y_pos[RW+1] && (y_pos[RW:0] < (RW+1)'(h_c))
                      && !x_pos[WW+1] && (x_pos[WW:0] < (WW+1)'(w_c));
   assign j_end     = j_ff == $signed(SW'(r_c));
   assign i_end     = i_ff == $signed(SW'(r_c));

   // memories
   logic [23:0] glow_rdata;
   logic [63:0] pix_rdata;

   lbdf_ram #(.WIDTH(24), .DEPTH(GLOW_DEPTH)) u_glow_ram (
      .clock   (clock),
      .wr_en   (cmd.op == lbdf_pkg::OP_STORE),
      .wr_addr (glow_wp_ff),
      .wr_data (glow_ff),
      .rd_en   (cmd.op == lbdf_pkg::OP_DISK),
      .rd_addr (GAW'(glow_rd_x)),
      .rd_data (glow_rdata)
   );

   lbdf_ram #(.WIDTH(64), .DEPTH(PIX_DEPTH)) u_pix_ram (
      .clock   (clock),
      .wr_en   (cmd.op == lbdf_pkg::OP_FETCH),
      .wr_addr (pix_wp_ff),
      .wr_data (pix_ff),
      .rd_en   (cmd.op == lbdf_pkg::OP_STORE),
      .rd_addr (PAW'(pix_rd_x)),
      .rd_data (pix_rdata)
   );

   // output values
   logic [TW-1:0] sum_r;
   logic [TW-1:0] sum_g;
   logic [TW-1:0] sum_b;
   logic          last;
   logic          out_free;
   logic          in_wrap;
   logic          out_wrap;

   assign sum_r    = TW'(src_ff[15:0]) + total_ff;
   assign sum_g    = TW'(src_ff[31:16]) + total_ff;
   assign sum_b    = TW'(src_ff[47:32]) + total_ff;
   assign last     = (out_row_ff >= RW'(h_c) - RW'(1)) && (out_col_ff >= w_c - WW'(1));
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign in_wrap  = ((WW+1)'(in_col_ff) + (WW+1)'(1)) >= (WW+1)'(w_c);
   assign out_wrap = ((WW+1)'(out_col_ff) + (WW+1)'(1)) >= (WW+1)'(w_c);

   assign sts.full_factor = full_ff;
   assign sts.div_last    = cnt_ff == 4'd15;
   assign sts.emit        = emit_ff;
   assign sts.disk_last   = i_end && j_end;
   assign sts.out_free    = out_free;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         glow_wp_ff   <= '0;
         pix_wp_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= (cmd.op == lbdf_pkg::OP_DISK) && in_disk;
         if (cmd.op == lbdf_pkg::OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.op == lbdf_pkg::OP_STORE) begin
            glow_wp_ff <= (glow_wp_ff == GAW'(GLOW_DEPTH - 1)) ? '0 : glow_wp_ff + GAW'(1);
         end
         if (cmd.op == lbdf_pkg::OP_FETCH) begin
            pix_wp_ff <= (pix_wp_ff == PAW'(PIX_DEPTH - 1)) ? '0 : pix_wp_ff + PAW'(1);
            if (in_wrap) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + RW'(1);
            end else begin
               in_col_ff <= in_col_ff + WW'(1);
            end
         end
         if (cmd.op == lbdf_pkg::OP_EMIT) begin
            if (last) begin
               in_col_ff  <= '0;
               in_row_ff  <= '0;
               out_col_ff <= '0;
               out_row_ff <= '0;
            end else if (out_wrap) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + RW'(1);
            end else begin
               out_col_ff <= out_col_ff + WW'(1);
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      case (cmd.op)
         lbdf_pkg::OP_ACCEPT: begin
            pad_ff <= req_pad;
            pix_ff <= req_pad ? 64'd0 : {req_alpha, req_blue, req_green, req_red};
         end
         lbdf_pkg::OP_LUMA_R: begin
            acc_ff <= 34'(wprod);
            rw_ff  <= DW'(r_c) * DW'(w_c);
            q_ff   <= QW'(in_row_ff) * QW'(w_c) + QW'(in_col_ff);
         end
         lbdf_pkg::OP_LUMA_G: begin
            acc_ff   <= acc_ff + 34'(wprod);
            delay_ff <= rw_ff + DW'(r_c);
         end
         lbdf_pkg::OP_LUMA_B: begin
            acc_ff  <= acc_ff + 34'(wprod);
            emit_ff <= CW'(q_ff) >= CW'(delay_ff);
         end
         lbdf_pkg::OP_CLAMP: begin
            luma_ff <= luma_c;
            full_ff <= (cfg.threshold == 16'd0) || (luma_c >= cfg.threshold);
            rem_ff  <= luma_c;
            quo_ff  <= '0;
            cnt_ff  <= '0;
         end
         lbdf_pkg::OP_DIV: begin
            rem_ff <= rem_ge ? 16'(rem2 - {1'b0, cfg.threshold}) : rem2[15:0];
            quo_ff <= {quo_ff[14:0], rem_ge};
            cnt_ff <= cnt_ff + 4'd1;
         end
         lbdf_pkg::OP_MUL_FACTOR: begin
            prod_ff <= mf[31:16];
         end
         lbdf_pkg::OP_MUL_GAIN: begin
            glow_ff <= pad_ff ? 24'd0 : mg[39:16];
         end
         lbdf_pkg::OP_STORE: begin
            cur_g_ff <= glow_wp_ff;
         end
         lbdf_pkg::OP_FETCH: begin
            src_ff      <= (delay_ff == '0) ? pix_ff : pix_rdata;
            i_ff        <= -$signed(SW'(r_c));
            j_ff        <= -$signed(SW'(r_c));
            back_ff     <= {delay_ff, 1'b0};
            row_back_ff <= {delay_ff, 1'b0};
            total_ff    <= '0;
         end
         lbdf_pkg::OP_DISK: begin
            if (rd_valid_ff) begin
               total_ff <= total_ff + TW'(glow_rdata);
            end
            if (j_end) begin
               j_ff        <= -$signed(SW'(r_c));
               i_ff        <= i_ff + SW'(1);
               row_back_ff <= row_back_ff - BW'(w_c);
               back_ff     <= row_back_ff - BW'(w_c);
            end else begin
               j_ff    <= j_ff + SW'(1);
               back_ff <= back_ff - BW'(1);
            end
         end
         lbdf_pkg::OP_DRAIN: begin
            if (rd_valid_ff) begin
               total_ff <= total_ff + TW'(glow_rdata);
            end
         end
         lbdf_pkg::OP_EMIT: begin
            rsp_red_ff   <= (sum_r > TW'(16'hFFFF)) ? 16'hFFFF : sum_r[15:0];
            rsp_green_ff <= (sum_g > TW'(16'hFFFF)) ? 16'hFFFF : sum_g[15:0];
            rsp_blue_ff  <= (sum_b > TW'(16'hFFFF)) ? 16'hFFFF : sum_b[15:0];
            rsp_alpha_ff <= src_ff[63:48];
            rsp_eof_ff   <= last;
         end
         default: begin
         end
      endcase
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_red      = rsp_red_ff;
   assign rsp_if.out_green    = rsp_green_ff;
   assign rsp_if.out_blue     = rsp_blue_ff;
   assign rsp_if.out_alpha    = rsp_alpha_ff;
   assign rsp_if.end_of_frame = rsp_eof_ff;

   a_rd_valid_from_disk: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(cmd.op == lbdf_pkg::OP_DISK))
      else $error("disk tap valid without a disk read");

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == lbdf_pkg::OP_EMIT |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("result loaded over an untaken result");

   a_glow_wp_range: assert property (@(posedge clock) disable iff (reset)
      32'(glow_wp_ff) < GLOW_DEPTH)
      else $error("glow write pointer out of range");

   a_pix_wp_range: assert property (@(posedge clock) disable iff (reset)
      32'(pix_wp_ff) < PIX_DEPTH)
      else $error("pixel write pointer out of range");
endmodule

[rtl/luminance_bloom_disk_filter.sv]
// top level of the luminance bloom disk filter
//
// usage
//   req_if carries RGBA pixels in raster order (Q4.12) plus an is_pad flag; a
//   transfer happens when valid and ready are high at a rising clock edge
//   rsp_if carries the bloomed pixel, alpha unchanged and end_of_frame on the
//   last pixel of the frame
//   csr_if writes the eight settings by index; always ready, write only while idle
//   results lag the input by radius*width+radius items, so the host appends that
//   many pad items after each frame
// throughput
//   one item at a time: before the next input transfer an item passes accept, three
//   luma products, clamp, the divider state, factor and gain products, store and
//   fetch; the 16 step divider runs only when luma is under the threshold
//   an item that gives a result then walks the (2*radius+1)^2 disk taps, drains
//   and emits once the output register is free; valid rises the cycle after emit
// reset
//   synchronous, clears position counters, ring pointers and the output flag,
//   settings go to their defaults; line memories need no clearing
// stall
//   a finished result waits in the output register; the next item is taken
//   meanwhile and holds only at the point where it would load its own result
module luminance_bloom_disk_filter #(
   parameter int MAX_RADIUS = lbdf_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = lbdf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lbdf_pkg::MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lbdf_req_if.sink    req_if,
   lbdf_rsp_if.source  rsp_if,
   lbdf_csr_if.sink    csr_if
);
   lbdf_pkg::cfg_type cfg_ff;
   lbdf_pkg::cmd_type cmd;
   lbdf_pkg::sts_type sts;
   logic              req_ready;

   // settings registers, writes always taken
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.weight_red   <= lbdf_pkg::RST_WEIGHT_RED;
         cfg_ff.weight_green <= lbdf_pkg::RST_WEIGHT_GREEN;
         cfg_ff.weight_blue  <= lbdf_pkg::RST_WEIGHT_BLUE;
         cfg_ff.threshold    <= lbdf_pkg::RST_THRESHOLD;
         cfg_ff.gain         <= lbdf_pkg::RST_GAIN;
         cfg_ff.radius       <= lbdf_pkg::RST_RADIUS;
         cfg_ff.width        <= lbdf_pkg::RST_WIDTH;
         cfg_ff.height       <= lbdf_pkg::RST_HEIGHT;
      end else if (csr_if.valid) begin
         case (lbdf_pkg::csr_index_type'(csr_if.index))
            lbdf_pkg::REG_LUMA_WEIGHT_RED:   cfg_ff.weight_red   <= csr_if.data[15:0];
            lbdf_pkg::REG_LUMA_WEIGHT_GREEN: cfg_ff.weight_green <= csr_if.data[15:0];
            lbdf_pkg::REG_LUMA_WEIGHT_BLUE:  cfg_ff.weight_blue  <= csr_if.data[15:0];
            lbdf_pkg::REG_GLOW_THRESHOLD:    cfg_ff.threshold    <= csr_if.data[15:0];
            lbdf_pkg::REG_GLOW_GAIN:         cfg_ff.gain         <= csr_if.data[23:0];
            lbdf_pkg::REG_DISK_RADIUS:       cfg_ff.radius       <= csr_if.data[3:0];
            lbdf_pkg::REG_FRAME_WIDTH:       cfg_ff.width        <= csr_if.data[10:0];
            lbdf_pkg::REG_FRAME_HEIGHT:      cfg_ff.height       <= csr_if.data[10:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   lbdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_if.ready = req_ready;

   // glow math, line memories, disk gather, output register
   lbdf_datapath #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .sts       (sts),
      .req_red   (req_if.in_red),
      .req_green (req_if.in_green),
      .req_blue  (req_if.in_blue),
      .req_alpha (req_if.in_alpha),
      .req_pad   (req_if.is_pad),
      .rsp_if    (rsp_if)
   );
endmodule

[tb/tb_luminance_bloom_disk_filter.sv]
// self-checking testbench of the luminance bloom disk filter
module tb_luminance_bloom_disk_filter;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
      logic        pad;
   } pixel_item_type;

   typedef struct {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
      logic        eof;
   } bloom_pixel_type;

   logic clock;
   logic reset;

   lbdf_req_if req_bus ();
   lbdf_rsp_if rsp_bus ();
   lbdf_csr_if csr_bus ();

   luminance_bloom_disk_filter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // clock, 10 ns period
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   pixel_item_type  pixels_to_send[$];
   bloom_pixel_type bloomed_pending[$];

   // shadow of the settings, updated on each csr transfer
   lbdf_pkg::cfg_type shadow_cfg;

   // per-frame glow and pixel history, keyed by raster position
   logic [23:0] glow_by_pos[int];
   logic [63:0] pixel_by_pos[int];
   int          in_pos;

   int   errors      = 0;
   int   frames_done = 0;
   int   results_seen = 0;
   int   items_sent  = 0;
   bit   idle_on     = 1'b1;
   bit   hold_request = 1'b0;
   bit   hold_done;
   int   hold_left;
   int   gap_left;
   int   stall_left;

   // luminance and glow of one source pixel under the current settings
   function automatic logic [23:0] glow_of(logic [15:0] r, logic [15:0] g, logic [15:0] b);
      longint unsigned luma;
      longint unsigned factor;
      luma = (64'(shadow_cfg.weight_red) * 64'(r) + 64'(shadow_cfg.weight_green) * 64'(g)
              + 64'(shadow_cfg.weight_blue) * 64'(b)) >> 16;
      if (luma > 65535) luma = 65535;
      if (luma >= 64'(shadow_cfg.threshold)) factor = 65536;
      else factor = (luma << 16) / 64'(shadow_cfg.threshold);
      return 24'((((luma * factor) >> 16) * 64'(shadow_cfg.gain)) >> 16);
   endfunction

   function automatic logic [15:0] sat16(longint unsigned v);
      return (v > 65535) ? 16'hFFFF : 16'(v);
   endfunction

   // accept one pixel, record its glow, and queue the bloomed pixel it releases
   function automatic void bloom_accept(pixel_item_type it);
      int w, h, r, lag, p, oy, ox, i, j, x, y;
      logic [31:0] row_acc;
      longint unsigned glow_sum;
      logic [63:0] src;
      bloom_pixel_type res;
      w = (shadow_cfg.width == 0) ? 1 : (shadow_cfg.width > lbdf_pkg::MAX_WIDTH_DEF) ?
          lbdf_pkg::MAX_WIDTH_DEF : int'(shadow_cfg.width);
      h = (shadow_cfg.height == 0) ? 1 : (shadow_cfg.height > lbdf_pkg::MAX_HEIGHT_DEF) ?
          lbdf_pkg::MAX_HEIGHT_DEF : int'(shadow_cfg.height);
      r = (shadow_cfg.radius > lbdf_pkg::MAX_RADIUS_DEF) ? lbdf_pkg::MAX_RADIUS_DEF :
          int'(shadow_cfg.radius);
      lag = r * w + r;
      // a pad is a black, transparent pixel with no glow
      glow_by_pos[in_pos]  = it.pad ? 24'd0 : glow_of(it.red, it.green, it.blue);
      pixel_by_pos[in_pos] = it.pad ? 64'd0 : {it.alpha, it.blue, it.green, it.red};
      if (in_pos < lag) begin
         in_pos++;
         return;
      end
      p  = in_pos - lag;
      oy = p / w;
      ox = p % w;
      glow_sum = 0;
      for (i = -r; i <= r; i++) begin
         row_acc = 0;
         y = oy + i;
         if (y >= 0 && y < h) begin
            for (j = -r; j <= r; j++) begin
               x = ox + j;
               if (i * i + j * j <= r * r && x >= 0 && x < w)
                  row_acc += 32'(glow_by_pos[p + i * w + j]);
            end
         end
         glow_sum += row_acc;
      end
      src = pixel_by_pos[p];
      res.red   = sat16(64'(src[15:0]) + glow_sum);
      res.green = sat16(64'(src[31:16]) + glow_sum);
      res.blue  = sat16(64'(src[47:32]) + glow_sum);
      res.alpha = src[63:48];
      res.eof   = (p == w * h - 1);
      bloomed_pending.push_back(res);
      if (res.eof) begin
         // frame done: positions return to the origin
         in_pos = 0;
         glow_by_pos.delete();
         pixel_by_pos.delete();
      end else begin
         in_pos++;
      end
   endfunction

   // settings follow every csr transfer
   always @(posedge clock) begin
      if (reset) begin
         shadow_cfg <= '{lbdf_pkg::RST_WEIGHT_RED, lbdf_pkg::RST_WEIGHT_GREEN,
                         lbdf_pkg::RST_WEIGHT_BLUE, lbdf_pkg::RST_THRESHOLD,
                         lbdf_pkg::RST_GAIN, lbdf_pkg::RST_RADIUS, lbdf_pkg::RST_WIDTH,
                         lbdf_pkg::RST_HEIGHT};
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (lbdf_pkg::csr_index_type'(csr_bus.index))
            lbdf_pkg::REG_LUMA_WEIGHT_RED:   shadow_cfg.weight_red   <= csr_bus.data[15:0];
            lbdf_pkg::REG_LUMA_WEIGHT_GREEN: shadow_cfg.weight_green <= csr_bus.data[15:0];
            lbdf_pkg::REG_LUMA_WEIGHT_BLUE:  shadow_cfg.weight_blue  <= csr_bus.data[15:0];
            lbdf_pkg::REG_GLOW_THRESHOLD:    shadow_cfg.threshold    <= csr_bus.data[15:0];
            lbdf_pkg::REG_GLOW_GAIN:         shadow_cfg.gain         <= csr_bus.data[23:0];
            lbdf_pkg::REG_DISK_RADIUS:       shadow_cfg.radius       <= csr_bus.data[3:0];
            lbdf_pkg::REG_FRAME_WIDTH:       shadow_cfg.width        <= csr_bus.data[10:0];
            lbdf_pkg::REG_FRAME_HEIGHT:      shadow_cfg.height       <= csr_bus.data[10:0];
            default: ;
         endcase
      end
   end

   // pixel driver: holds valid until the transfer, random idle bursts in between
   always @(posedge clock) begin
      bit fire;
      fire = req_bus.valid && req_bus.ready;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
         in_pos = 0;
      end else begin
         if (fire) begin
            bloom_accept(pixels_to_send.pop_front());
            items_sent++;
         end
         if (req_bus.valid && !fire) begin
            // hold the offered pixel
         end else if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pixels_to_send.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 12);
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid    <= 1'b1;
            req_bus.in_red   <= pixels_to_send[0].red;
            req_bus.in_green <= pixels_to_send[0].green;
            req_bus.in_blue  <= pixels_to_send[0].blue;
            req_bus.in_alpha <= pixels_to_send[0].alpha;
            req_bus.is_pad   <= pixels_to_send[0].pad;
         end
      end
   end

   // long receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_left <= 6000;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result ready with random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 12);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= (hold_left == 0);
      end
   end

   // result monitor: compare each transfer with the oldest bloomed pixel
   always @(posedge clock) begin
      bloom_pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (bloomed_pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result r=%h g=%h b=%h a=%h eof=%b", $time,
                     rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue,
                     rsp_bus.out_alpha, rsp_bus.end_of_frame);
         end else begin
            want = bloomed_pending.pop_front();
            if (rsp_bus.out_red !== want.red) begin
               errors++;
               $display("%0t: out_red expected %h actual %h", $time, want.red,
                        rsp_bus.out_red);
            end
            if (rsp_bus.out_green !== want.green) begin
               errors++;
               $display("%0t: out_green expected %h actual %h", $time, want.green,
                        rsp_bus.out_green);
            end
            if (rsp_bus.out_blue !== want.blue) begin
               errors++;
               $display("%0t: out_blue expected %h actual %h", $time, want.blue,
                        rsp_bus.out_blue);
            end
            if (rsp_bus.out_alpha !== want.alpha) begin
               errors++;
               $display("%0t: out_alpha expected %h actual %h", $time, want.alpha,
                        rsp_bus.out_alpha);
            end
            if (rsp_bus.end_of_frame !== want.eof) begin
               errors++;
               $display("%0t: end_of_frame expected %b actual %b", $time, want.eof,
                        rsp_bus.end_of_frame);
            end
            if (want.eof) frames_done++;
         end
      end
   end

   // one csr transfer; valid stays high across back-to-back writes
   task automatic csr_write(lbdf_pkg::csr_index_type idx, logic [23:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   // write all eight settings; returns frame size and lag in pixels under clamped values
   task automatic set_frame(logic [15:0] wr, logic [15:0] wg, logic [15:0] wb,
                            logic [15:0] thr, logic [23:0] gain, logic [3:0] rad,
                            logic [10:0] width, logic [10:0] height,
                            output int pixels, output int lag);
      int w, h, r;
      csr_write(lbdf_pkg::REG_LUMA_WEIGHT_RED, 24'(wr));
      csr_write(lbdf_pkg::REG_LUMA_WEIGHT_GREEN, 24'(wg));
      csr_write(lbdf_pkg::REG_LUMA_WEIGHT_BLUE, 24'(wb));
      csr_write(lbdf_pkg::REG_GLOW_THRESHOLD, 24'(thr));
      csr_write(lbdf_pkg::REG_GLOW_GAIN, gain);
      csr_write(lbdf_pkg::REG_DISK_RADIUS, 24'(rad));
      csr_write(lbdf_pkg::REG_FRAME_WIDTH, 24'(width));
      csr_write(lbdf_pkg::REG_FRAME_HEIGHT, 24'(height));
      csr_bus.valid <= 1'b0;
      w = (width == 0) ? 1 : (width > lbdf_pkg::MAX_WIDTH_DEF) ? lbdf_pkg::MAX_WIDTH_DEF :
          int'(width);
      h = (height == 0) ? 1 : (height > lbdf_pkg::MAX_HEIGHT_DEF) ?
          lbdf_pkg::MAX_HEIGHT_DEF : int'(height);
      r = (rad > lbdf_pkg::MAX_RADIUS_DEF) ? lbdf_pkg::MAX_RADIUS_DEF : int'(rad);
      pixels = w * h;
      lag = r * w + r;
   endtask

   function automatic logic [15:0] channel_value();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 8191));
         default: return 16'($urandom);
      endcase
   endfunction

   // frame of random pixels with occasional in-frame pads, then the trailing pads
   task automatic push_frame(int pixels, int lag);
      pixel_item_type it;
      for (int k = 0; k < pixels + lag; k++) begin
         it.red   = channel_value();
         it.green = channel_value();
         it.blue  = channel_value();
         it.alpha = 16'($urandom);
         it.pad   = (k >= pixels) || ($urandom_range(0, 15) == 0);
         pixels_to_send.push_back(it);
      end
   endtask

   // wait until every pixel went out and every result came back, then let the block settle
   task automatic wait_idle();
      while (pixels_to_send.size() != 0 || bloomed_pending.size() != 0 || req_bus.valid)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   initial begin
      int pixels, lag, random_items;
      pixel_item_type it;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.in_red = '0;
      req_bus.in_green = '0;
      req_bus.in_blue  = '0;
      req_bus.in_alpha = '0;
      req_bus.is_pad   = 1'b0;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = '0;
      csr_bus.data   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed 5x5 frame: channel extremes, single-channel pixels, in-frame pads
      set_frame(lbdf_pkg::RST_WEIGHT_RED, lbdf_pkg::RST_WEIGHT_GREEN,
                lbdf_pkg::RST_WEIGHT_BLUE, lbdf_pkg::RST_THRESHOLD, lbdf_pkg::RST_GAIN,
                4'd2, 11'd5, 11'd5, pixels, lag);
      for (int k = 0; k < pixels + lag; k++) begin
         it = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0};
         case (k % 8)
            0: it = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0};
            1: it.red = 16'hFFFF;
            2: it.green = 16'hFFFF;
            3: it.blue = 16'hFFFF;
            4: it.pad = 1'b1;
            5: it = '{16'h0800, 16'h0800, 16'h0800, 16'h5555, 1'b0};
            6: it.alpha = 16'hFFFF;
            default: it = '{16'h1000, 16'h0400, 16'h2000, 16'hAAAA, 1'b0};
         endcase
         if (k >= pixels) it.pad = 1'b1;
         pixels_to_send.push_back(it);
      end
      wait_idle();

      // radius zero, threshold zero, full gain and weights
      set_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 24'hFFFFFF, 4'd0, 11'd3, 11'd2,
                pixels, lag);
      push_frame(pixels, lag);
      wait_idle();

      // oversized radius on a frame of one pixel given as zero width and height
      set_frame(16'd0, 16'd0, 16'd0, 16'hFFFF, 24'd0, 4'd15, 11'd0, 11'd0, pixels, lag);
      push_frame(pixels, lag);
      wait_idle();

      // random frames; the first one sees a long receiver hold-off
      random_items = 0;
      while (random_items < 330) begin
         if (random_items > 250) idle_on = 1'b0;
         set_frame(16'($urandom), 16'($urandom), 16'($urandom),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16)) : 16'($urandom),
                   ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000)),
                   ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4)),
                   11'($urandom_range(1, 8)), 11'($urandom_range(1, 6)), pixels, lag);
         if (random_items == 0) hold_request = 1'b1;
         push_frame(pixels, lag);
         random_items += pixels + lag;
         wait_idle();
      end

      $display("covered %0d frames, %0d pixels in, %0d bloomed pixels checked",
               frames_done, items_sent, results_seen);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // timeout guard
   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/lbdf_pkg.sv
rtl/lbdf_ifs.sv
rtl/lbdf_ram.sv
rtl/lbdf_ctrl.sv
rtl/lbdf_datapath.sv
rtl/luminance_bloom_disk_filter.sv
tb/tb_luminance_bloom_disk_filter.sv
